// ===== hdl/rc_pulse_capture_esc_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// RC pulse capture / ESC mixer assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_CAPTURE_ESC_MIXER_MACROS_SVH
`define RC_PULSE_CAPTURE_ESC_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RCPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcpc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RCPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcpc assertion failed");

`endif

// ===== hdl/rcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpc_pkg
// Types, constants and helpers shared by the pulse capture / mixer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpc_pkg;

    localparam int COUNT_WIDTH_DEF     = 12;
    localparam int DUTY_FULL_SCALE_DEF = 8191;
    localparam int PERIOD_US_DEF       = 20000;

    localparam int US_W       = 12;
    localparam int DUTY_W     = 10;
    localparam int DB_W       = 9;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_CTR   = 3'd6;

    localparam logic            SWAP_RST      = 1'b0;
    localparam logic [DB_W-1:0] DEADBAND_RST  = 9'd30;
    localparam logic [US_W-1:0] VALID_MIN_RST = 12'd800;
    localparam logic [US_W-1:0] VALID_MAX_RST = 12'd2200;
    localparam logic [US_W-1:0] PWM_MIN_RST   = 12'd1000;
    localparam logic [US_W-1:0] PWM_MAX_RST   = 12'd2000;
    localparam logic [US_W-1:0] PWM_CTR_RST   = 12'd1500;
    localparam logic [US_W-1:0] HELD_RST      = 12'd1500;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;

    typedef struct packed {
        logic                   line_a_level;
        logic                   line_b_level;
        logic signed [US_W-1:0] steer_correction;
    } rcpc_in_t;

    typedef struct packed {
        logic [US_W-1:0]   left_width_us;
        logic [US_W-1:0]   right_width_us;
        logic [US_W-1:0]   steer_width_us;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] steer_duty;
    } rcpc_out_t;

    typedef struct packed {
        logic            swap_channels;
        logic [DB_W-1:0] deadband_us;
        logic [US_W-1:0] valid_min_us;
        logic [US_W-1:0] valid_max_us;
        logic [US_W-1:0] pwm_min_us;
        logic [US_W-1:0] pwm_max_us;
        logic [US_W-1:0] pwm_center_us;
    } rcpc_cfg_t;

    // throttle / steer after deadband, with the correction riding along
    typedef struct packed {
        logic [US_W-1:0]        thr;
        logic [US_W-1:0]        str;
        logic signed [US_W-1:0] corr;
    } rcpc_shaped_t;

    typedef struct packed {
        logic [US_W-1:0] left;
        logic [US_W-1:0] right;
        logic [US_W-1:0] steer;
    } rcpc_widths_t;

    // Below lo gives lo first; with an inverted range, values below lo give lo and all others give hi.
    function automatic logic [US_W-1:0] clamp_pwm(
        input logic signed [US_W+1:0] v,
        input logic [US_W-1:0]        lo,
        input logic [US_W-1:0]        hi
    );
        logic signed [US_W+1:0] lo_s;
        logic signed [US_W+1:0] hi_s;
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        if (v < lo_s) begin
            return lo;
        end else if (v > hi_s) begin
            return hi;
        end else begin
            return v[US_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rcpc_capture.sv =====
// ----------------------------------------------------------------------------
// rcpc_capture
// High-time counter and held width for one receiver line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_pulse_capture_esc_mixer_macros.svh"

module rcpc_capture #(
    parameter int COUNT_WIDTH = rcpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ld,
    input  wire logic                       level,
    input  wire logic [rcpc_pkg::US_W-1:0]  valid_min_us,
    input  wire logic [rcpc_pkg::US_W-1:0]  valid_max_us,
    output logic      [rcpc_pkg::US_W-1:0]  held
);
    import rcpc_pkg::*;

    logic                   prev_reg;
    logic                   prev_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [US_W-1:0]        held_reg;
    logic [US_W-1:0]        held_next;
    logic                   rise;
    logic                   fall;
    logic                   in_window;

    assign rise = level & ~prev_reg;
    assign fall = ~level & prev_reg;

    // saturates at all ones
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign count_next = rise ? '0 : count_inc;
    assign in_window  = (count_next >= COUNT_WIDTH'(valid_min_us)) &&
                        (count_next <= COUNT_WIDTH'(valid_max_us));
    assign held_next  = (fall && in_window) ? count_next[US_W-1:0] : held_reg;
    assign prev_next  = level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 1'b0;
            count_reg <= '1;
            held_reg  <= HELD_RST;
        end else if (ld) begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    assign held = held_reg;

    `RCPC_ASSERT_NEXT(a_rise_clears, aclk, aresetn, ld && rise, count_reg == '0)
    `RCPC_ASSERT_NEXT(a_sat_holds, aclk, aresetn, ld && !rise && count_reg == '1, count_reg == '1)
    `RCPC_ASSERT_NEXT(a_held_idle, aclk, aresetn, !ld, $stable(held_reg))

endmodule

`default_nettype wire

// ===== hdl/rcpc_shaper.sv =====
// ----------------------------------------------------------------------------
// rcpc_shaper
// Channel select, deadband around center and clamp for throttle and steer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpc_shaper (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rcpc_pkg::rcpc_cfg_t           cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rcpc_pkg::US_W-1:0]     held_a,
    input  wire logic [rcpc_pkg::US_W-1:0]     held_b,
    input  wire logic signed [rcpc_pkg::US_W-1:0] corr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rcpc_pkg::rcpc_shaped_t             out_data
);
    import rcpc_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    rcpc_shaped_t data_reg;
    rcpc_shaped_t data_next;

    function automatic logic [US_W-1:0] deadband(
        input logic [US_W-1:0] w,
        input rcpc_cfg_t       c
    );
        logic signed [US_W:0] diff;
        logic [US_W:0]        mag;
        diff = $signed({1'b0, w}) - $signed({1'b0, c.pwm_center_us});
        mag  = diff[US_W] ? (US_W+1)'(-diff) : diff;
        if (mag < (US_W+1)'(c.deadband_us)) begin
            return c.pwm_center_us;
        end else begin
            return clamp_pwm($signed({2'b00, w}), c.pwm_min_us, c.pwm_max_us);
        end
    endfunction

    always_comb begin
        data_next.thr  = deadband(cfg.swap_channels ? held_b : held_a, cfg);
        data_next.str  = deadband(cfg.swap_channels ? held_a : held_b, cfg);
        data_next.corr = corr;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/rcpc_mixer.sv =====
// ----------------------------------------------------------------------------
// rcpc_mixer
// Differential mix of throttle and yaw correction into left / right widths.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpc_mixer (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire rcpc_pkg::rcpc_cfg_t     cfg,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rcpc_pkg::rcpc_shaped_t  in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rcpc_pkg::rcpc_widths_t       out_data
);
    import rcpc_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    rcpc_widths_t           data_reg;
    rcpc_widths_t           data_next;
    logic signed [US_W+1:0] thr_s;
    logic signed [US_W+1:0] corr_s;

    // no correction while throttle sits at neutral
    assign thr_s  = $signed({2'b00, in_data.thr});
    assign corr_s = (in_data.thr == cfg.pwm_center_us) ? '0 :
                    $signed({{2{in_data.corr[US_W-1]}}, in_data.corr});

    always_comb begin
        data_next.left  = clamp_pwm(thr_s - corr_s, cfg.pwm_min_us, cfg.pwm_max_us);
        data_next.right = clamp_pwm(thr_s + corr_s, cfg.pwm_min_us, cfg.pwm_max_us);
        data_next.steer = in_data.str;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/rcpc_duty.sv =====
// ----------------------------------------------------------------------------
// rcpc_duty
// Width to duty scaling (reciprocal multiply) and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpc_duty #(
    parameter int DUTY_FULL_SCALE = rcpc_pkg::DUTY_FULL_SCALE_DEF,
    parameter int PERIOD_US       = rcpc_pkg::PERIOD_US_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rcpc_pkg::rcpc_widths_t  in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rcpc_pkg::rcpc_out_t          out_data
);
    import rcpc_pkg::*;

    // floor(us * FS / P) == (us * ceil(FS * 2^S / P)) >> S for us < 2^US_W
    localparam int DUTY_SHIFT = US_W + $clog2(PERIOD_US + 1);
    localparam longint unsigned DUTY_MULT =
        ((64'(DUTY_FULL_SCALE) << DUTY_SHIFT) + 64'(PERIOD_US) - 64'd1) / 64'(PERIOD_US);
    localparam int MULT_W = $clog2(DUTY_MULT + 1);
    localparam int PROD_W = US_W + MULT_W;

    logic      valid_reg;
    logic      valid_next;
    rcpc_out_t data_reg;
    rcpc_out_t data_next;

    function automatic logic [DUTY_W-1:0] to_duty(input logic [US_W-1:0] us);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        prod = PROD_W'(us) * PROD_W'(DUTY_MULT);
        quo  = prod >> DUTY_SHIFT;
        if (quo > PROD_W'(DUTY_MAX)) begin
            return DUTY_MAX;
        end else begin
            return quo[DUTY_W-1:0];
        end
    endfunction

    always_comb begin
        data_next.left_width_us  = in_data.left;
        data_next.right_width_us = in_data.right;
        data_next.steer_width_us = in_data.steer;
        data_next.left_duty      = to_duty(in_data.left);
        data_next.right_duty     = to_duty(in_data.right);
        data_next.steer_duty     = to_duty(in_data.steer);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/rc_pulse_capture_esc_mixer.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_capture_esc_mixer
// RC receiver pulse capture with deadband, clamp and differential ESC mix.
// ----------------------------------------------------------------------------
//   port group   dir  handshake            beat contents
//   s_*          in   s_valid / s_ready    line levels + steer correction
//   m_*          out  m_valid / m_ready    3 widths (us) + 3 duty values
//   cfg_wr_*     in   cfg_wr_en            register index + data, no wait
//
// One beat per cycle sustained while m_ready holds high; m_valid follows the s_ accept
// edge through the registers capture, deadband/clamp, mix/clamp, duty multiply + result.
// Each stage holds while its successor is full, so a stalled m_ side
// still lets s_ beats fill empty stages.
// Reset restores register defaults, saturates both counters, centers held widths.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_pulse_capture_esc_mixer_macros.svh"

module rc_pulse_capture_esc_mixer #(
    parameter int COUNT_WIDTH     = rcpc_pkg::COUNT_WIDTH_DEF,
    parameter int DUTY_FULL_SCALE = rcpc_pkg::DUTY_FULL_SCALE_DEF,
    parameter int PERIOD_US       = rcpc_pkg::PERIOD_US_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire rcpc_pkg::rcpc_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output rcpc_pkg::rcpc_out_t                  m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rcpc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [rcpc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import rcpc_pkg::*;

    rcpc_cfg_t              cfg_reg;
    rcpc_cfg_t              cfg_next;
    logic                   v1_reg;
    logic                   v1_next;
    logic signed [US_W-1:0] corr_reg;
    logic                   ld;
    logic [US_W-1:0]        held_a;
    logic [US_W-1:0]        held_b;
    logic                   shp_ready;
    logic                   shp_valid;
    rcpc_shaped_t           shp_data;
    logic                   mix_ready;
    logic                   mix_valid;
    rcpc_widths_t           mix_data;
    logic                   duty_ready;

    // configuration
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_SWAP:      cfg_next.swap_channels = cfg_wr_data[0];
                CFG_DEADBAND:  cfg_next.deadband_us   = cfg_wr_data[DB_W-1:0];
                CFG_VALID_MIN: cfg_next.valid_min_us  = cfg_wr_data[US_W-1:0];
                CFG_VALID_MAX: cfg_next.valid_max_us  = cfg_wr_data[US_W-1:0];
                CFG_PWM_MIN:   cfg_next.pwm_min_us    = cfg_wr_data[US_W-1:0];
                CFG_PWM_MAX:   cfg_next.pwm_max_us    = cfg_wr_data[US_W-1:0];
                CFG_PWM_CTR:   cfg_next.pwm_center_us = cfg_wr_data[US_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swap_channels <= SWAP_RST;
            cfg_reg.deadband_us   <= DEADBAND_RST;
            cfg_reg.valid_min_us  <= VALID_MIN_RST;
            cfg_reg.valid_max_us  <= VALID_MAX_RST;
            cfg_reg.pwm_min_us    <= PWM_MIN_RST;
            cfg_reg.pwm_max_us    <= PWM_MAX_RST;
            cfg_reg.pwm_center_us <= PWM_CTR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // stage 1: capture state doubles as the input register
    assign s_ready = !v1_reg || shp_ready;
    assign ld      = s_valid && s_ready;
    assign v1_next = s_ready ? s_valid : v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            corr_reg <= s_data.steer_correction;
        end
    end

    rcpc_capture #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cap_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ld           (ld),
        .level        (s_data.line_a_level),
        .valid_min_us (cfg_reg.valid_min_us),
        .valid_max_us (cfg_reg.valid_max_us),
        .held         (held_a)
    );

    rcpc_capture #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cap_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ld           (ld),
        .level        (s_data.line_b_level),
        .valid_min_us (cfg_reg.valid_min_us),
        .valid_max_us (cfg_reg.valid_max_us),
        .held         (held_b)
    );

    rcpc_shaper u_shaper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (v1_reg),
        .in_ready  (shp_ready),
        .held_a    (held_a),
        .held_b    (held_b),
        .corr      (corr_reg),
        .out_valid (shp_valid),
        .out_ready (mix_ready),
        .out_data  (shp_data)
    );

    rcpc_mixer u_mixer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (shp_valid),
        .in_ready  (mix_ready),
        .in_data   (shp_data),
        .out_valid (mix_valid),
        .out_ready (duty_ready),
        .out_data  (mix_data)
    );

    rcpc_duty #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
        .PERIOD_US       (PERIOD_US)
    ) u_duty (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (duty_ready),
        .in_data   (mix_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    `RCPC_ASSERT_IMP(a_empty_takes_beat, aclk, aresetn, !v1_reg, s_ready)
    `RCPC_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, v1_reg)
    `RCPC_ASSERT_IMP(a_duty_lanes_match, aclk, aresetn,
        m_valid && (m_data.left_width_us == m_data.right_width_us),
        m_data.left_duty == m_data.right_duty)

endmodule

`default_nettype wire
